// ===== hdl/prc_pkg.sv =====
// shared types, constants and reset values of the poll request coalescer
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

  localparam int unsigned PacketSlotsDef = 128;

  localparam logic [6:0]  SlotNumMax  = 7'h7f;
  localparam logic [7:0]  PktCntMax   = 8'hff;
  localparam logic [9:0]  EntryCntMax = 10'd1023;
  localparam logic [7:0]  WordMask    = 8'hff;

  // result kinds
  localparam logic KindPlace = 1'b0;
  localparam logic KindDesc  = 1'b1;

  // register reset values
  localparam logic        BitModeRst    = 1'b0;
  localparam logic [7:0]  FuncCodeRst   = 8'd3;
  localparam logic [6:0]  MaxWordsRst   = 7'd100;
  localparam logic        ContigRst     = 1'b0;
  localparam logic [7:0]  SelTypeRst    = 8'd4;

  localparam logic [7:0] OneHot [8] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80
  };

  typedef enum logic [2:0] {
    CFG_BIT_MODE  = 3'd0,
    CFG_FUNC_CODE = 3'd1,
    CFG_MAX_WORDS = 3'd2,
    CFG_CONTIG    = 3'd3,
    CFG_SEL_TYPE  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic        bit_mode;
    logic [7:0]  function_code;
    logic [6:0]  max_packet_words;
    logic        require_contiguous;
    logic [7:0]  selected_type;
  } cfg_t;

  typedef struct packed {
    logic [15:0] reg_address;
    logic [7:0]  entry_type;
    logic [9:0]  entry_position;
    logic        final_entry;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  packet_number;
    logic [7:0]  byte_offset;
    logic [7:0]  bit_select;
    logic [15:0] first_address;
    logic [9:0]  first_position;
    logic [9:0]  quantity;
    logic [7:0]  command_code;
    logic        slots_exhausted;
    logic        run_end;
  } out_t;

  // results of one request, handed from the packer to the result buffer
  typedef struct packed {
    logic           valid;
    logic [1:0]     count;
    out_t [2:0]     res;
  } load_t;

endpackage

`default_nettype wire

// ===== hdl/prc_cfg_regs.sv =====
// configuration register file of the poll request coalescer
`timescale 1ns / 1ps
`default_nettype none

module prc_cfg_regs (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i,
  output prc_pkg::cfg_t     cfg_o
);

  prc_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_mode           <= prc_pkg::BitModeRst;
      cfg_q.function_code      <= prc_pkg::FuncCodeRst;
      cfg_q.max_packet_words   <= prc_pkg::MaxWordsRst;
      cfg_q.require_contiguous <= prc_pkg::ContigRst;
      cfg_q.selected_type      <= prc_pkg::SelTypeRst;
    end else if (cfg_valid_i) begin
      unique case (prc_pkg::cfg_idx_e'(cfg_index_i))
        prc_pkg::CFG_BIT_MODE:  cfg_q.bit_mode           <= cfg_data_i[0];
        prc_pkg::CFG_FUNC_CODE: cfg_q.function_code      <= cfg_data_i;
        prc_pkg::CFG_MAX_WORDS: cfg_q.max_packet_words   <= cfg_data_i[6:0];
        prc_pkg::CFG_CONTIG:    cfg_q.require_contiguous <= cfg_data_i[0];
        prc_pkg::CFG_SEL_TYPE:  cfg_q.selected_type      <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/prc_packer.sv =====
// input register, open packet state and per-request result generation
`timescale 1ns / 1ps
`default_nettype none

module prc_packer #(
  parameter int unsigned PACKET_SLOTS = prc_pkg::PacketSlotsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire prc_pkg::in_t  in_data_i,
  input  wire prc_pkg::cfg_t cfg_i,
  input  wire logic          can_load_i,
  output prc_pkg::load_t     load_o
);

  localparam logic [8:0] Slots    = 9'(PACKET_SLOTS);
  localparam logic [8:0] SlotLast = 9'(PACKET_SLOTS - 1);

  logic          inq_valid_q;
  prc_pkg::in_t  inq_q;
  logic          take;

  logic          open_q, open_d;
  logic [15:0]   start_q, start_d;
  logic [15:0]   prev_q, prev_d;
  logic [9:0]    fpos_q, fpos_d;
  logic [9:0]    cnt_q, cnt_d;
  logic [7:0]    pc_q, pc_d;

  logic          match;
  logic [6:0]    words;
  logic [9:0]    limit;
  logic [15:0]   span_o, step, span_b;
  logic          close_a, open_a, open_b, close_f;
  logic [15:0]   start_b, start_c, prev_b;
  logic [9:0]    fpos_b, fpos_c, cnt_b;
  logic [7:0]    pc_a, pc_b;
  logic [1:0]    n;
  prc_pkg::out_t [2:0] res;

  function automatic logic [7:0] pc_inc(input logic [7:0] pc);
    return (pc == prc_pkg::PktCntMax) ? pc : pc + 8'd1;
  endfunction

  function automatic logic [6:0] slot_num(input logic [7:0] pc);
    return ({1'b0, pc} >= SlotLast) ? SlotLast[6:0] : pc[6:0];
  endfunction

  function automatic prc_pkg::out_t mk_desc(input logic [7:0] pc, input logic [15:0] st,
                                            input logic [9:0] fp, input logic [15:0] pv,
                                            input logic [7:0] cmd);
    prc_pkg::out_t r;
    logic [15:0]   d;
    d                 = pv - st;
    r                 = '0;
    r.result_kind     = prc_pkg::KindDesc;
    r.packet_number   = slot_num(pc);
    r.first_address   = st;
    r.first_position  = fp;
    r.quantity        = d[9:0] + 10'd1;
    r.command_code    = cmd;
    r.slots_exhausted = ({1'b0, pc} >= Slots);
    return r;
  endfunction

  assign take       = inq_valid_q && can_load_i;
  assign in_ready_o = !inq_valid_q || take;

  always_comb begin
    match   = (inq_q.entry_type == cfg_i.selected_type);
    words   = (cfg_i.max_packet_words == 7'd0) ? 7'd1 : cfg_i.max_packet_words;
    limit   = cfg_i.bit_mode ? {words, 3'b000} : {3'b000, words};
    span_o  = inq_q.reg_address - start_q;
    step    = inq_q.reg_address - prev_q;
    close_a = open_q && match &&
              (span_o >= {6'b0, limit} || cnt_q >= limit ||
               (cfg_i.require_contiguous && step != 16'd1));
    open_a  = open_q && !close_a;
    start_b = open_a ? start_q : inq_q.reg_address;
    fpos_b  = open_a ? fpos_q : inq_q.entry_position;
    cnt_b   = open_a ? cnt_q : 10'd0;
    pc_a    = close_a ? pc_inc(pc_q) : pc_q;
    span_b  = inq_q.reg_address - start_b;
    start_c = match ? start_b : start_q;
    fpos_c  = match ? fpos_b : fpos_q;
    prev_b  = match ? inq_q.reg_address : prev_q;
    open_b  = open_q || match;
    close_f = inq_q.final_entry && open_b;
    pc_b    = close_f ? pc_inc(pc_a) : pc_a;

    res = '0;
    n   = 2'd0;
    if (close_a) begin
      res[n] = mk_desc(pc_q, start_q, fpos_q, prev_q, cfg_i.function_code);
      n      = n + 2'd1;
    end
    if (match) begin
      res[n].result_kind     = prc_pkg::KindPlace;
      res[n].packet_number   = slot_num(pc_a);
      res[n].byte_offset     = cfg_i.bit_mode ? span_b[10:3] : {span_b[6:0], 1'b0};
      res[n].bit_select      = cfg_i.bit_mode ? prc_pkg::OneHot[span_b[2:0]]
                                              : prc_pkg::WordMask;
      res[n].first_address   = start_b;
      res[n].first_position  = fpos_b;
      res[n].slots_exhausted = ({1'b0, pc_a} >= Slots);
      n = n + 2'd1;
    end
    if (close_f) begin
      res[n] = mk_desc(pc_a, start_c, fpos_c, prev_b, cfg_i.function_code);
      n      = n + 2'd1;
    end
    if (n != 2'd0) begin
      res[n - 2'd1].run_end = 1'b1;
    end

    open_d  = open_b && !close_f;
    start_d = start_c;
    fpos_d  = fpos_c;
    cnt_d   = match ? ((cnt_b == prc_pkg::EntryCntMax) ? cnt_b : cnt_b + 10'd1) : cnt_q;
    prev_d  = prev_b;
    pc_d    = pc_b;
  end

  assign load_o.valid = take;
  assign load_o.count = n;
  assign load_o.res   = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
      open_q      <= 1'b0;
      start_q     <= '0;
      prev_q      <= '0;
      fpos_q      <= '0;
      cnt_q       <= '0;
      pc_q        <= '0;
    end else begin
      if (in_ready_o) begin
        inq_valid_q <= in_valid_i;
      end
      if (take) begin
        open_q  <= open_d;
        start_q <= start_d;
        prev_q  <= prev_d;
        fpos_q  <= fpos_d;
        cnt_q   <= cnt_d;
        pc_q    <= pc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      inq_q <= in_data_i;
    end
  end

  // closed packet count only moves up
  a_pc_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q >= $past(pc_q))
    else $error("packet counter went backwards");

  // three results only come from a close, a placement and a final close
  a_three_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_o.valid && load_o.count == 2'd3) |->
      (load_o.res[0].result_kind == prc_pkg::KindDesc &&
       load_o.res[1].result_kind == prc_pkg::KindPlace &&
       load_o.res[2].result_kind == prc_pkg::KindDesc))
    else $error("bad result order in a three-result load");

endmodule

`default_nettype wire

// ===== hdl/prc_result_buf.sv =====
// three-slot result register that drains one result per cycle while out_ready_i is high
`timescale 1ns / 1ps
`default_nettype none

module prc_result_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire prc_pkg::load_t  load_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output prc_pkg::out_t        out_data_o
);

  prc_pkg::out_t [2:0] slots_q;
  logic [1:0]          cnt_q;
  logic                pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slots_q[0];
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i.valid) begin
      cnt_q <= load_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      slots_q <= load_i.res;
    end else if (pop) begin
      slots_q[0] <= slots_q[1];
      slots_q[1] <= slots_q[2];
    end
  end

  // a new load never overwrites results still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.valid |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)))
    else $error("result load over pending results");

  // the last pending result closes its request
  a_last_has_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cnt_q == 2'd1) |-> out_data_o.run_end)
    else $error("last pending result lacks run_end");

endmodule

`default_nettype wire

// ===== hdl/poll_request_coalescer.sv =====
// Poll request coalescer: groups table entries of one type into read packets.
// Entries come in on the in_* channel (valid/ready), ascending by address.
// Every matching entry gives a placement result; each packet that closes
// gives a descriptor result. Results leave on the out_* channel, one per
// handshake, and run_end marks the last result of one request.
// Registers are written on the cfg_* channel (index, data); cfg_ready_o is
// always high. Write them only while no request is in flight.
// A request is taken into the input register; its results are computed from
// there and loaded into the result register once that register can take them,
// and its first result is then valid on the out_* channel.
// Requests are taken one per cycle while each yields at most one result and
// the receiver is ready; a request with two or three results holds the input
// until the single output port has drained the result register to its last.
// When the receiver stalls, results wait in the result register and one
// further request waits in the input register; then in_ready_o drops.
// Reset clears the register file to its defaults, closes any open packet and
// zeroes the packet counter; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module poll_request_coalescer #(
  parameter int unsigned PACKET_SLOTS = prc_pkg::PacketSlotsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire prc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output prc_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i
);

  prc_pkg::cfg_t  cfg;
  prc_pkg::load_t load;
  logic           can_load;

  prc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  prc_packer #(
    .PACKET_SLOTS (PACKET_SLOTS)
  ) u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .can_load_i (can_load),
    .load_o     (load)
  );

  prc_result_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
